[src/wwmv_pkg.sv]
`timescale 1ns / 1ps

package wwmv_pkg;

    // Data widths
    localparam int SAMPLE_WIDTH = 16;
    localparam int FRAC_BITS    = 16;
    localparam int CNT_W        = 16;
    localparam int MEAN_W       = SAMPLE_WIDTH + FRAC_BITS;
    localparam int DELTA_W      = MEAN_W + 1;
    localparam int SQ_W         = 64;
    localparam int VAR_W        = 48;
    localparam int OUT_MEAN_W   = 32;

    // Shared divider: the dividend register is as wide as the widest dividend.
    localparam int DIVD_W = SQ_W;
    localparam int STEP_W = $clog2(DIVD_W + 1);

    // Deviation multiplier: the second factor is split into two slices.
    localparam int LO_W   = DELTA_W / 2;
    localparam int HI_W   = DELTA_W - LO_W;
    localparam int PP_W   = DELTA_W + HI_W;
    localparam int PROD_W = 2 * DELTA_W;

    // Register port
    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-1:0] ADDR_WINDOW  = PADDR_W'(0);
    localparam logic [CNT_W-1:0]   WINDOW_RESET = CNT_W'(256);

    localparam logic [VAR_W-1:0] VAR_MAX = '1;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [CNT_W-1:0]  divisor;
        logic [STEP_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIVD_W-1:0] quotient;
        logic [CNT_W-1:0]  remainder;
    } div_rsp_t;

    typedef struct packed {
        logic               start;
        logic [DELTA_W-1:0] a;
        logic [DELTA_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic            done;
        logic [SQ_W-1:0] p;
    } mul_rsp_t;

endpackage

[src/wwmv_div.sv]
`timescale 1ns / 1ps

module wwmv_div
    import wwmv_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIVD_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  dsr_reg, dsr_next;
    logic [STEP_W-1:0] left_reg, left_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [CNT_W:0]    trial;
    logic              fits;

    // Restoring division, one quotient bit per cycle. The dividend arrives
    // left aligned, so after the requested number of steps the quotient sits
    // in the low bits of the shift register.
    assign trial = {rem_reg, quo_reg[DIVD_W-1]};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        left_next = left_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (busy_reg)
        begin
            rem_next  = fits ? CNT_W'(trial - {1'b0, dsr_reg}) : trial[CNT_W-1:0];
            quo_next  = {quo_reg[DIVD_W-2:0], fits};
            left_next = left_reg - STEP_W'(1);
            if (left_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
            left_next = req.steps;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            rem_reg  <= '0;
            dsr_reg  <= '0;
            left_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            dsr_reg  <= dsr_next;
            left_reg <= left_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

[src/wwmv_mul.sv]
`timescale 1ns / 1ps

module wwmv_mul
    import wwmv_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    localparam int RND_W = PROD_W + 1;
    localparam int EXT_W = RND_W + SQ_W;

    typedef enum logic [2:0] {
        M_IDLE,
        M_LO,
        M_HI,
        M_ACC,
        M_RND
    } mul_state_t;

    mul_state_t         state_reg, state_next;
    logic [DELTA_W-1:0] a_reg, a_next;
    logic [DELTA_W-1:0] b_reg, b_next;
    logic [PP_W-1:0]    pp_reg, pp_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [SQ_W-1:0]    p_reg, p_next;
    logic               done_reg, done_next;

    logic [HI_W-1:0]    slice;
    logic [PP_W-1:0]    pp;
    logic [RND_W-1:0]   rnd;
    logic [EXT_W-1:0]   scaled;
    logic               sat;

    // One narrow multiplier serves both slices of the second factor.
    assign slice  = (state_reg == M_HI) ? b_reg[DELTA_W-1:LO_W] : HI_W'(b_reg[LO_W-1:0]);
    assign pp     = PP_W'(a_reg) * PP_W'(slice);

    // Round half up to FRAC_BITS fraction bits, then clamp to the sum width.
    assign rnd    = {1'b0, prod_reg} + (RND_W'(1) << (FRAC_BITS - 1));
    assign scaled = EXT_W'(rnd) >> FRAC_BITS;
    assign sat    = |scaled[EXT_W-1:SQ_W];

    always_comb
    begin
        state_next = state_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        pp_next    = pp_reg;
        prod_next  = prod_reg;
        p_next     = p_reg;
        done_next  = 1'b0;
        case (state_reg)
            M_IDLE:
            begin
                if (req.start)
                begin
                    a_next     = req.a;
                    b_next     = req.b;
                    state_next = M_LO;
                end
            end
            M_LO:
            begin
                pp_next    = pp;
                state_next = M_HI;
            end
            M_HI:
            begin
                pp_next    = pp;
                prod_next  = PROD_W'(pp_reg);
                state_next = M_ACC;
            end
            M_ACC:
            begin
                prod_next  = prod_reg + (PROD_W'(pp_reg) << LO_W);
                state_next = M_RND;
            end
            M_RND:
            begin
                p_next     = sat ? '1 : scaled[SQ_W-1:0];
                done_next  = 1'b1;
                state_next = M_IDLE;
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            a_reg     <= '0;
            b_reg     <= '0;
            pp_reg    <= '0;
            prod_reg  <= '0;
            p_reg     <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
            pp_reg    <= pp_next;
            prod_reg  <= prod_next;
            p_reg     <= p_next;
            done_reg  <= done_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.p    = p_reg;

endmodule

[src/windowed_welford_mean_variance_core.sv]
`timescale 1ns / 1ps

// Channel | Handshake          | Beat payload
// in      | in_valid, in_ready   | sample
// out     | out_valid, out_ready | count, mean_value, variance_value
// cfg     | psel, penable, pready | paddr, pwrite, pwdata, prdata (window_length)
//
// An accumulator update is paced by the shared divider, which produces one
// quotient bit per cycle. A sample updates one accumulator or both; the
// variance division is skipped while the active count is below two.
// Reset clears both accumulators, selects the first one and sets the window to
// 256. A new sample is taken while the previous result still waits at the
// output; the block only stalls at its end if that result has not yet gone.

module windowed_welford_mean_variance_core
    import wwmv_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic        [CNT_W-1:0]        count,
    output logic signed [OUT_MEAN_W-1:0]   mean_value,
    output logic        [VAR_W-1:0]        variance_value,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic        [PADDR_W-1:0]      paddr,
    input  logic        [PDATA_W-1:0]      pwdata,
    output logic        [PDATA_W-1:0]      prdata,
    output logic                           pready
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DELTA,
        S_MDIV,
        S_EDEV,
        S_MUL,
        S_SWAP,
        S_VAR,
        S_VDIV,
        S_OUT
    } state_t;

    state_t                     state_reg, state_next;
    logic        [CNT_W-1:0]    wl_reg, wl_next;
    logic        [CNT_W-1:0]    acc_cnt_reg [2];
    logic        [CNT_W-1:0]    acc_cnt_next [2];
    logic signed [MEAN_W-1:0]   acc_mean_reg [2];
    logic signed [MEAN_W-1:0]   acc_mean_next [2];
    logic        [SQ_W-1:0]     acc_sq_reg [2];
    logic        [SQ_W-1:0]     acc_sq_next [2];
    logic                       act_reg, act_next;
    logic                       k_reg, k_next;
    logic signed [MEAN_W-1:0]   xq_reg, xq_next;
    logic                       dneg_reg, dneg_next;
    logic        [DELTA_W-1:0]  dm_reg, dm_next;
    logic                       add_reg, add_next;
    logic        [VAR_W-1:0]    var_reg, var_next;
    logic                       out_valid_reg, out_valid_next;
    logic        [CNT_W-1:0]    count_reg, count_next;
    logic signed [OUT_MEAN_W-1:0] mean_out_reg, mean_out_next;
    logic        [VAR_W-1:0]    var_out_reg, var_out_next;

    div_req_t div_req;
    div_rsp_t div_rsp;
    mul_req_t mul_req;
    mul_rsp_t mul_rsp;

    logic                       sel;
    logic        [CNT_W-1:0]    cnt_rd;
    logic signed [MEAN_W-1:0]   mean_rd;
    logic        [SQ_W-1:0]     sq_rd;
    logic signed [DELTA_W-1:0]  delta_w;
    logic        [DELTA_W-1:0]  dm_w;
    logic        [CNT_W-1:0]    n_w;
    logic        [DELTA_W-1:0]  mdiv_sum;
    logic signed [DELTA_W:0]    mean_ext;
    logic signed [DELTA_W:0]    q_ext;
    logic signed [DELTA_W:0]    mean_sum;
    logic        [SQ_W:0]       sq_sum;
    logic        [SQ_W-1:0]     sq_new;
    logic        [CNT_W-1:0]    vdiv_d;
    logic                       vround;
    logic        [SQ_W:0]       var_sum;
    logic                       apb_wr;

    // Both accumulators sit behind one index: the one under update while the
    // sample is folded in, the active one from the swap onwards.
    assign sel     = (state_reg inside {S_SWAP, S_VAR, S_VDIV, S_OUT}) ? act_reg : k_reg;
    assign cnt_rd  = acc_cnt_reg[sel];
    assign mean_rd = acc_mean_reg[sel];
    assign sq_rd   = acc_sq_reg[sel];

    // The same subtractor gives delta before the mean update and the new
    // deviation after it, since the sample is held throughout.
    assign delta_w  = DELTA_W'(xq_reg) - DELTA_W'(mean_rd);
    assign dm_w     = delta_w[DELTA_W-1] ? -delta_w : delta_w;
    assign n_w      = (&cnt_rd) ? cnt_rd : cnt_rd + CNT_W'(1);
    assign mdiv_sum = dm_w + DELTA_W'(n_w >> 1);

    assign mean_ext = (DELTA_W + 1)'(mean_rd);
    assign q_ext    = $signed({1'b0, div_rsp.quotient[DELTA_W-1:0]});
    assign mean_sum = dneg_reg ? mean_ext - q_ext : mean_ext + q_ext;

    assign sq_sum = {1'b0, sq_rd} + {1'b0, mul_rsp.p};
    always_comb
    begin
        if (add_reg)
        begin
            sq_new = sq_sum[SQ_W] ? '1 : sq_sum[SQ_W-1:0];
        end
        else
        begin
            sq_new = (sq_rd > mul_rsp.p) ? sq_rd - mul_rsp.p : '0;
        end
    end

    assign vdiv_d  = cnt_rd - CNT_W'(1);
    assign vround  = ({div_rsp.remainder, 1'b0} >= {1'b0, vdiv_d});
    assign var_sum = {1'b0, div_rsp.quotient} + (SQ_W + 1)'(vround);

    assign apb_wr = psel && penable && pwrite && (paddr == ADDR_WINDOW);

    always_comb
    begin
        state_next     = state_reg;
        wl_next        = wl_reg;
        acc_cnt_next   = acc_cnt_reg;
        acc_mean_next  = acc_mean_reg;
        acc_sq_next    = acc_sq_reg;
        act_next       = act_reg;
        k_next         = k_reg;
        xq_next        = xq_reg;
        dneg_next      = dneg_reg;
        dm_next        = dm_reg;
        add_next       = add_reg;
        var_next       = var_reg;
        out_valid_next = out_valid_reg && !out_ready;
        count_next     = count_reg;
        mean_out_next  = mean_out_reg;
        var_out_next   = var_out_reg;
        div_req        = '0;
        mul_req        = '0;

        if (apb_wr)
        begin
            wl_next = pwdata[CNT_W-1:0];
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    xq_next    = {sample, FRAC_BITS'(0)};
                    k_next     = act_reg;
                    state_next = S_DELTA;
                end
            end
            S_DELTA:
            begin
                acc_cnt_next[sel] = n_w;
                dneg_next         = delta_w[DELTA_W-1];
                dm_next           = dm_w;
                div_req.start     = 1'b1;
                div_req.dividend  = DIVD_W'(mdiv_sum) << (DIVD_W - DELTA_W);
                div_req.divisor   = n_w;
                div_req.steps     = STEP_W'(DELTA_W);
                state_next        = S_MDIV;
            end
            S_MDIV:
            begin
                if (div_rsp.done)
                begin
                    acc_mean_next[sel] = mean_sum[MEAN_W-1:0];
                    state_next         = S_EDEV;
                end
            end
            S_EDEV:
            begin
                // A zero factor adds nothing, so it takes the adding path.
                add_next      = (dneg_reg == delta_w[DELTA_W-1]) || (dm_reg == '0)
                                || (dm_w == '0);
                mul_req.start = 1'b1;
                mul_req.a     = dm_reg;
                mul_req.b     = dm_w;
                state_next    = S_MUL;
            end
            S_MUL:
            begin
                if (mul_rsp.done)
                begin
                    acc_sq_next[sel] = sq_new;
                    if ((k_reg == act_reg) && (cnt_rd > (wl_reg >> 1)))
                    begin
                        k_next     = ~k_reg;
                        state_next = S_DELTA;
                    end
                    else
                    begin
                        state_next = S_SWAP;
                    end
                end
            end
            S_SWAP:
            begin
                if (cnt_rd >= wl_reg)
                begin
                    act_next           = ~act_reg;
                    acc_cnt_next[sel]  = '0;
                    acc_mean_next[sel] = '0;
                    acc_sq_next[sel]   = '0;
                end
                state_next = S_VAR;
            end
            S_VAR:
            begin
                if (cnt_rd >= CNT_W'(2))
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DIVD_W'(sq_rd);
                    div_req.divisor  = vdiv_d;
                    div_req.steps    = STEP_W'(DIVD_W);
                    state_next       = S_VDIV;
                end
                else
                begin
                    var_next   = '0;
                    state_next = S_OUT;
                end
            end
            S_VDIV:
            begin
                if (div_rsp.done)
                begin
                    var_next   = (var_sum > (SQ_W + 1)'(VAR_MAX)) ? VAR_MAX
                                                                  : var_sum[VAR_W-1:0];
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    count_next     = cnt_rd;
                    mean_out_next  = OUT_MEAN_W'(mean_rd);
                    var_out_next   = var_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wl_reg        <= WINDOW_RESET;
            acc_cnt_reg   <= '{default: '0};
            acc_mean_reg  <= '{default: '0};
            acc_sq_reg    <= '{default: '0};
            act_reg       <= 1'b0;
            k_reg         <= 1'b0;
            xq_reg        <= '0;
            dneg_reg      <= 1'b0;
            dm_reg        <= '0;
            add_reg       <= 1'b0;
            var_reg       <= '0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            mean_out_reg  <= '0;
            var_out_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            wl_reg        <= wl_next;
            acc_cnt_reg   <= acc_cnt_next;
            acc_mean_reg  <= acc_mean_next;
            acc_sq_reg    <= acc_sq_next;
            act_reg       <= act_next;
            k_reg         <= k_next;
            xq_reg        <= xq_next;
            dneg_reg      <= dneg_next;
            dm_reg        <= dm_next;
            add_reg       <= add_next;
            var_reg       <= var_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            mean_out_reg  <= mean_out_next;
            var_out_reg   <= var_out_next;
        end
    end

    wwmv_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    wwmv_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign count          = count_reg;
    assign mean_value     = mean_out_reg;
    assign variance_value = var_out_reg;
    assign pready         = 1'b1;
    assign prdata         = (paddr == ADDR_WINDOW) ? PDATA_W'(wl_reg) : '0;

endmodule

[src/wwmv_checker.sv]
`timescale 1ns / 1ps

module wwmv_checker
    import wwmv_pkg::*;
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic        [CNT_W-1:0]        count,
    input logic signed [OUT_MEAN_W-1:0]   mean_value,
    input logic        [VAR_W-1:0]        variance_value
);

    // A result beat that is held back keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(count) && $stable(mean_value)
                                    && $stable(variance_value))
        else $error("result beat changed while stalled");

    // A taken sample keeps the block busy, so in_ready drops after it.
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second sample taken straight after the first");

    // The active accumulator always holds at least the latest sample.
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> count != '0)
        else $error("result reports an empty accumulator");

    a_var_small_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (count < CNT_W'(2)) |-> variance_value == '0)
        else $error("variance reported for fewer than two samples");

endmodule

bind windowed_welford_mean_variance_core wwmv_checker u_wwmv_checker (.*);
